### design/ocdm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ocdm_pkg: shared types and constants for the orbit camera
// Function codes, register indexes, controller command word and the fixed
// point constants used by the datapath and the sine table.
// ---------------------------------------------------------------------------
package ocdm_pkg;

    // function codes of an input word
    localparam logic [1:0] FUNC_RATE = 2'd0;
    localparam logic [1:0] FUNC_ZOOM = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_TARGET_X  = 3'd0;
    localparam logic [2:0] CFG_TARGET_Y  = 3'd1;
    localparam logic [2:0] CFG_TARGET_Z  = 3'd2;
    localparam logic [2:0] CFG_ANG_DAMP  = 3'd3;
    localparam logic [2:0] CFG_ZOOM_DAMP = 3'd4;
    localparam logic [2:0] CFG_MAX_ANG   = 3'd5;
    localparam logic [2:0] CFG_MAX_ZOOM  = 3'd6;
    localparam logic [2:0] CFG_MAX_PITCH = 3'd7;

    // configuration reset values
    localparam logic [26:0] ANG_DAMP_RESET  = 27'd683565;
    localparam logic [24:0] ZOOM_DAMP_RESET = 25'd167772;
    localparam logic [28:0] MAX_ANG_RESET   = 29'd6835652;
    localparam logic [23:0] MAX_ZOOM_RESET  = 24'd1677722;
    localparam logic [30:0] MAX_PITCH_RESET = 31'd966367642;

    // distance limits and gains
    localparam logic [30:0] ZOOM_MIN_Q24   = 31'd33554;
    localparam logic [30:0] ZOOM_MAX_Q24   = 31'd1593835520;
    localparam logic [30:0] ZOOM_RESET_Q24 = 31'd838861;
    localparam logic [30:0] ZOOM_GAIN_Q24  = 31'd503316;
    localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;

    // sine table construction
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam int unsigned TAYLOR_TERMS = 8;
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // multiplier operand selections
    localparam logic [2:0] MUL_UPD   = 3'd0;
    localparam logic [2:0] MUL_SP_Z  = 3'd1;
    localparam logic [2:0] MUL_SY_CP = 3'd2;
    localparam logic [2:0] MUL_P_Z   = 3'd3;
    localparam logic [2:0] MUL_CY_CP = 3'd4;

    // trig term selections: sine and cosine of pitch and yaw
    localparam logic [1:0] TRIG_SP = 2'd0;
    localparam logic [1:0] TRIG_CP = 2'd1;
    localparam logic [1:0] TRIG_SY = 2'd2;
    localparam logic [1:0] TRIG_CY = 2'd3;

    // command word from controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       upd;
        logic       fin;
        logic       trig_rd;
        logic [1:0] trig_rd_sel;
        logic       trig_lat;
        logic [1:0] trig_lat_sel;
        logic       mul_en;
        logic [2:0] mul_op;
        logic       grab_y;
        logic       grab_z;
        logic       load_out;
    } t_cmd;

endpackage

### design/ocdm_sine_rom.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ocdm_sine_rom: quarter-wave sine table
// Q1.16 entries built at elaboration from a truncated Taylor sum; read data
// is registered, and an address at or beyond the depth reads one.
// ---------------------------------------------------------------------------
module ocdm_sine_rom #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rd,
    input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] i_addr,
    output logic [16:0]                           o_data
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IW = $clog2(SINE_TABLE_DEPTH);

    typedef logic [16:0] t_tab [SINE_TABLE_DEPTH];

    // table contents, worked out at elaboration
    function automatic t_tab f_build();
        t_tab        tab;
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            x = (64'(i) * ocdm_pkg::HALF_PI_Q30) / SINE_TABLE_DEPTH;
            t = x;
            s = x;
            for (int n = 0; n < ocdm_pkg::TAYLOR_TERMS; n++) begin
                t = (t * x) >> 30;
                t = (t * x) >> 30;
                t = t / ocdm_pkg::TAYLOR_DIV[n];
                if ((n % 2) == 0) begin
                    s = (t <= s) ? s - t : 64'd0;
                end else begin
                    s = s + t;
                end
            end
            q = (s + 64'd8192) >> 14;
            tab[i] = (q > 64'(ocdm_pkg::ONE_Q16)) ? ocdm_pkg::ONE_Q16 : q[16:0];
        end
        return tab;
    endfunction

    localparam t_tab TABLE = f_build();

    logic [16:0] r_data;

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            if (i_addr >= AW'(SINE_TABLE_DEPTH)) begin
                r_data <= ocdm_pkg::ONE_Q16;
            end else begin
                r_data <= TABLE[i_addr[IW-1:0]];
            end
        end
    end

    assign o_data = r_data;

endmodule

### design/ocdm_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ocdm_mul: shared unsigned multiplier
// One 33 by 31 bit product per cycle while i_en is high, held in a register until the next use.
// ---------------------------------------------------------------------------
module ocdm_mul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [32:0] i_a,
    input  logic [30:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    // product register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= 64'(i_a) * 64'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

### design/ocdm_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ocdm_datapath: camera state, configuration and position arithmetic
// Holds angles, distance and rates, applies each input word, looks up the
// four trig terms and forms the orbit position on the shared multiplier.
// ---------------------------------------------------------------------------
module ocdm_datapath #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ocdm_pkg::t_cmd      i_cmd,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  logic [1:0]          i_func,
    input  logic signed [31:0]  i_delta_yaw,
    input  logic signed [31:0]  i_delta_pitch,
    input  logic signed [24:0]  i_delta_zoom,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_pos_z,
    output logic [31:0]         o_yaw_now,
    output logic signed [31:0]  o_pitch_now,
    output logic [30:0]         o_zoom_now
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW = 30 + AW;

    // configuration
    logic signed [31:0] r_target_x;
    logic signed [31:0] r_target_y;
    logic signed [31:0] r_target_z;
    logic [26:0]        r_ang_damp;
    logic [24:0]        r_zoom_damp;
    logic [28:0]        r_max_ang;
    logic [23:0]        r_max_zoom;
    logic [30:0]        r_max_pitch;

    // camera state
    logic [31:0]        r_yaw;
    logic signed [31:0] r_pitch;
    logic [30:0]        r_dist;
    logic signed [31:0] r_yaw_rate;
    logic signed [31:0] r_pitch_rate;
    logic signed [25:0] r_zoom_rate;

    // captured input word
    logic [1:0]         r_func;
    logic signed [31:0] r_dy;
    logic signed [31:0] r_dp;
    logic signed [24:0] r_dz;

    // working registers
    logic               r_f_nonpos;
    logic               r_mneg;
    logic               r_rd_neg;
    logic [16:0]        r_sp;
    logic [16:0]        r_cp;
    logic [16:0]        r_sy;
    logic [16:0]        r_cy;
    logic               r_sp_neg;
    logic               r_cp_neg;
    logic               r_sy_neg;
    logic               r_cy_neg;
    logic signed [31:0] r_py;
    logic signed [31:0] r_pz;

    // output word
    logic signed [31:0] r_out_x;
    logic signed [31:0] r_out_y;
    logic signed [31:0] r_out_z;
    logic [31:0]        r_out_yaw;
    logic signed [31:0] r_out_pitch;
    logic [30:0]        r_out_zoom;

    // saturate a wide sum to 32 bits signed
    function automatic logic signed [31:0] f_sat32(input logic signed [37:0] v);
        logic signed [31:0] y;
        if (v > 38'sd2147483647) begin
            y = 32'sh7FFF_FFFF;
        end else if (v < -38'sd2147483648) begin
            y = 32'sh8000_0000;
        end else begin
            y = v[31:0];
        end
        return y;
    endfunction

    // move toward zero by d, then limit magnitude to m
    function automatic logic signed [33:0] f_damp_clamp(
        input logic signed [33:0] x,
        input logic signed [33:0] d,
        input logic signed [33:0] m
    );
        logic signed [33:0] y;
        if (x < -d) begin
            y = x + d;
        end else if (x > d) begin
            y = x - d;
        end else begin
            y = '0;
        end
        if (y < -m) begin
            y = -m;
        end else if (y > m) begin
            y = m;
        end
        return y;
    endfunction

    // target plus signed offset, saturated
    function automatic logic signed [31:0] f_sat_pos(
        input logic signed [31:0] base,
        input logic [24:0]        mag,
        input logic               neg
    );
        logic signed [33:0] m;
        logic signed [33:0] s;
        logic signed [31:0] y;
        m = $signed({9'b0, mag});
        if (neg) begin
            m = -m;
        end
        s = $signed({{2{base[31]}}, base}) + m;
        if (s > 34'sd2147483647) begin
            y = 32'sh7FFF_FFFF;
        end else if (s < -34'sd2147483648) begin
            y = 32'sh8000_0000;
        end else begin
            y = s[31:0];
        end
        return y;
    endfunction

    // rate increments, gain of twenty by shift and add
    logic signed [36:0] w_dy20;
    logic signed [36:0] w_dp20;
    logic signed [31:0] w_yaw_rate_add;
    logic signed [31:0] w_pitch_rate_add;

    assign w_dy20 = ($signed({{5{r_dy[31]}}, r_dy}) <<< 4)
                  + ($signed({{5{r_dy[31]}}, r_dy}) <<< 2);
    assign w_dp20 = ($signed({{5{r_dp[31]}}, r_dp}) <<< 4)
                  + ($signed({{5{r_dp[31]}}, r_dp}) <<< 2);
    assign w_yaw_rate_add   = f_sat32($signed({{6{r_yaw_rate[31]}}, r_yaw_rate})
                                      + $signed({w_dy20[36], w_dy20}));
    assign w_pitch_rate_add = f_sat32($signed({{6{r_pitch_rate[31]}}, r_pitch_rate})
                                      + $signed({w_dp20[36], w_dp20}));

    // tick: pitch step with limit, damped rates
    logic signed [32:0] w_pitch_sum;
    logic signed [32:0] w_max_pitch;
    logic signed [31:0] w_pitch_tick;
    logic signed [33:0] w_yaw_rate_dc;
    logic signed [33:0] w_pitch_rate_dc;
    logic signed [33:0] w_zoom_rate_dc;

    assign w_pitch_sum = $signed({r_pitch[31], r_pitch}) + $signed({r_pitch_rate[31], r_pitch_rate});
    assign w_max_pitch = $signed({2'b0, r_max_pitch});
    assign w_pitch_tick = (w_pitch_sum > w_max_pitch)  ? w_max_pitch[31:0] :
                          (w_pitch_sum < -w_max_pitch) ? 32'(-w_max_pitch) :
                          w_pitch_sum[31:0];

    assign w_yaw_rate_dc   = f_damp_clamp($signed({{2{r_yaw_rate[31]}}, r_yaw_rate}),
                                          $signed({7'b0, r_ang_damp}),
                                          $signed({5'b0, r_max_ang}));
    assign w_pitch_rate_dc = f_damp_clamp($signed({{2{r_pitch_rate[31]}}, r_pitch_rate}),
                                          $signed({7'b0, r_ang_damp}),
                                          $signed({5'b0, r_max_ang}));
    assign w_zoom_rate_dc  = f_damp_clamp($signed({{8{r_zoom_rate[25]}}, r_zoom_rate}),
                                          $signed({9'b0, r_zoom_damp}),
                                          $signed({10'b0, r_max_zoom}));

    // distance scale factor, one minus zoom rate
    logic signed [27:0] w_f;
    logic [24:0]        w_dz_mag;

    assign w_f      = 28'sd16777216 - $signed({{2{r_zoom_rate[25]}}, r_zoom_rate});
    assign w_dz_mag = r_dz[24] ? 25'(-r_dz) : 25'(r_dz);

    // shared multiplier and operand selection
    logic [63:0] w_prod;
    logic [32:0] w_mul_a;
    logic [30:0] w_mul_b;
    logic        w_mul_neg;

    always_comb begin
        w_mul_a   = '0;
        w_mul_b   = '0;
        w_mul_neg = 1'b0;
        unique case (i_cmd.mul_op)
            ocdm_pkg::MUL_UPD: begin
                if (r_func == ocdm_pkg::FUNC_ZOOM) begin
                    w_mul_a   = 33'(w_dz_mag);
                    w_mul_b   = ocdm_pkg::ZOOM_GAIN_Q24;
                    w_mul_neg = r_dz[24];
                end else begin
                    w_mul_a   = 33'(w_f[26:0]);
                    w_mul_b   = r_dist;
                end
            end
            ocdm_pkg::MUL_SP_Z: begin
                w_mul_a   = 33'(r_sp);
                w_mul_b   = r_dist;
                w_mul_neg = r_sp_neg;
            end
            ocdm_pkg::MUL_SY_CP: begin
                w_mul_a   = 33'(r_sy);
                w_mul_b   = 31'(r_cp);
                w_mul_neg = r_sy_neg ^ r_cp_neg;
            end
            ocdm_pkg::MUL_P_Z: begin
                w_mul_a   = w_prod[32:0];
                w_mul_b   = r_dist;
                w_mul_neg = r_mneg;
            end
            ocdm_pkg::MUL_CY_CP: begin
                w_mul_a   = 33'(r_cy);
                w_mul_b   = 31'(r_cp);
                w_mul_neg = r_cy_neg ^ r_cp_neg;
            end
            default: begin
                w_mul_a   = '0;
            end
        endcase
    end

    ocdm_mul u_mul (
        .i_clk (i_clk),
        .i_en  (i_cmd.mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // rounding of the product, half away from zero on the magnitude
    logic [63:0] w_rsum24;
    logic [63:0] w_rsum40;
    logic [39:0] w_r24;
    logic [23:0] w_r40;

    assign w_rsum24 = w_prod + 64'h0000_0000_0080_0000;
    assign w_rsum40 = w_prod + 64'h0000_0080_0000_0000;
    assign w_r24    = w_rsum24[63:24];
    assign w_r40    = w_rsum40[63:40];

    // product results: zoom rate, distance
    logic signed [27:0] w_zr_sum;
    logic signed [25:0] w_zoom_rate_add;
    logic [39:0]        w_nd;
    logic [30:0]        w_dist_tick;

    assign w_zr_sum = $signed({{2{r_zoom_rate[25]}}, r_zoom_rate})
                    + (r_mneg ? -$signed({8'b0, w_r24[19:0]}) : $signed({8'b0, w_r24[19:0]}));
    assign w_zoom_rate_add = (w_zr_sum > 28'sd33554431)  ? 26'sh1FF_FFFF :
                             (w_zr_sum < -28'sd33554432) ? 26'sh200_0000 :
                             w_zr_sum[25:0];
    assign w_nd = r_f_nonpos ? 40'd0 : w_r24;
    assign w_dist_tick = (w_nd < 40'(ocdm_pkg::ZOOM_MIN_Q24)) ? ocdm_pkg::ZOOM_MIN_Q24 :
                         (w_nd > 40'(ocdm_pkg::ZOOM_MAX_Q24)) ? ocdm_pkg::ZOOM_MAX_Q24 :
                         w_nd[30:0];

    // table address from angle: quadrant fold and index scaling
    logic [31:0]    w_ang;
    logic [PW-1:0]  w_idx_prod;
    logic [AW-1:0]  w_idx;
    logic [AW-1:0]  w_taddr;
    logic [16:0]    w_tdata;

    always_comb begin
        unique case (i_cmd.trig_rd_sel)
            ocdm_pkg::TRIG_SP: w_ang = $unsigned(r_pitch);
            ocdm_pkg::TRIG_CP: w_ang = $unsigned(r_pitch) + ocdm_pkg::QUARTER_TURN;
            ocdm_pkg::TRIG_SY: w_ang = r_yaw;
            ocdm_pkg::TRIG_CY: w_ang = r_yaw + ocdm_pkg::QUARTER_TURN;
        endcase
    end

    assign w_idx_prod = PW'(w_ang[29:0]) * PW'(SINE_TABLE_DEPTH);
    assign w_idx      = w_idx_prod[PW-1:30];
    assign w_taddr    = w_ang[30] ? AW'(SINE_TABLE_DEPTH) - w_idx : w_idx;

    ocdm_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_rd   (i_cmd.trig_rd),
        .i_addr (w_taddr),
        .o_data (w_tdata)
    );

    // configuration and camera state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x   <= '0;
            r_target_y   <= '0;
            r_target_z   <= '0;
            r_ang_damp   <= ocdm_pkg::ANG_DAMP_RESET;
            r_zoom_damp  <= ocdm_pkg::ZOOM_DAMP_RESET;
            r_max_ang    <= ocdm_pkg::MAX_ANG_RESET;
            r_max_zoom   <= ocdm_pkg::MAX_ZOOM_RESET;
            r_max_pitch  <= ocdm_pkg::MAX_PITCH_RESET;
            r_yaw        <= '0;
            r_pitch      <= '0;
            r_dist       <= ocdm_pkg::ZOOM_RESET_Q24;
            r_yaw_rate   <= '0;
            r_pitch_rate <= '0;
            r_zoom_rate  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ocdm_pkg::CFG_TARGET_X:  r_target_x  <= $signed(i_cfg_data);
                    ocdm_pkg::CFG_TARGET_Y:  r_target_y  <= $signed(i_cfg_data);
                    ocdm_pkg::CFG_TARGET_Z:  r_target_z  <= $signed(i_cfg_data);
                    ocdm_pkg::CFG_ANG_DAMP:  r_ang_damp  <= i_cfg_data[26:0];
                    ocdm_pkg::CFG_ZOOM_DAMP: r_zoom_damp <= i_cfg_data[24:0];
                    ocdm_pkg::CFG_MAX_ANG:   r_max_ang   <= i_cfg_data[28:0];
                    ocdm_pkg::CFG_MAX_ZOOM:  r_max_zoom  <= i_cfg_data[23:0];
                    ocdm_pkg::CFG_MAX_PITCH: r_max_pitch <= i_cfg_data[30:0];
                endcase
            end
            // first phase of the word
            if (i_cmd.upd) begin
                unique case (r_func)
                    ocdm_pkg::FUNC_RATE: begin
                        r_yaw_rate   <= w_yaw_rate_add;
                        r_pitch_rate <= w_pitch_rate_add;
                    end
                    ocdm_pkg::FUNC_TICK: begin
                        r_yaw        <= r_yaw + $unsigned(r_yaw_rate);
                        r_pitch      <= w_pitch_tick;
                        r_yaw_rate   <= w_yaw_rate_dc[31:0];
                        r_pitch_rate <= w_pitch_rate_dc[31:0];
                        r_zoom_rate  <= w_zoom_rate_dc[25:0];
                    end
                    default: begin
                    end
                endcase
            end
            // product phase: zoom rate or distance
            if (i_cmd.fin) begin
                unique case (r_func)
                    ocdm_pkg::FUNC_ZOOM: r_zoom_rate <= w_zoom_rate_add;
                    ocdm_pkg::FUNC_TICK: r_dist      <= w_dist_tick;
                    default: begin
                    end
                endcase
            end
        end
    end

    // input capture, trig terms, partial positions and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func <= i_func;
            r_dy   <= i_delta_yaw;
            r_dp   <= i_delta_pitch;
            r_dz   <= i_delta_zoom;
        end
        if (i_cmd.upd) begin
            r_f_nonpos <= (w_f <= 28'sd0);
        end
        if (i_cmd.mul_en) begin
            r_mneg <= w_mul_neg;
        end
        if (i_cmd.trig_rd) begin
            r_rd_neg <= w_ang[31];
        end
        if (i_cmd.trig_lat) begin
            unique case (i_cmd.trig_lat_sel)
                ocdm_pkg::TRIG_SP: begin
                    r_sp     <= w_tdata;
                    r_sp_neg <= r_rd_neg;
                end
                ocdm_pkg::TRIG_CP: begin
                    r_cp     <= w_tdata;
                    r_cp_neg <= r_rd_neg;
                end
                ocdm_pkg::TRIG_SY: begin
                    r_sy     <= w_tdata;
                    r_sy_neg <= r_rd_neg;
                end
                ocdm_pkg::TRIG_CY: begin
                    r_cy     <= w_tdata;
                    r_cy_neg <= r_rd_neg;
                end
            endcase
        end
        if (i_cmd.grab_y) begin
            r_py <= f_sat_pos(r_target_y, w_r24[24:0], r_mneg);
        end
        if (i_cmd.grab_z) begin
            r_pz <= f_sat_pos(r_target_z, {1'b0, w_r40}, r_mneg);
        end
        if (i_cmd.load_out) begin
            r_out_x     <= f_sat_pos(r_target_x, {1'b0, w_r40}, r_mneg);
            r_out_y     <= r_py;
            r_out_z     <= r_pz;
            r_out_yaw   <= r_yaw;
            r_out_pitch <= r_pitch;
            r_out_zoom  <= r_dist;
        end
    end

    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;
    assign o_pos_z     = r_out_z;
    assign o_yaw_now   = r_out_yaw;
    assign o_pitch_now = r_out_pitch;
    assign o_zoom_now  = r_out_zoom;

endmodule

### design/ocdm_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ocdm_ctrl: sequencer for the orbit camera
// Steps one input word through update, table reads and multiplies, and
// owns the handshakes of both channels.
// ---------------------------------------------------------------------------
module ocdm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ocdm_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_UPD  = 4'd1;
    localparam logic [3:0] S_FIN  = 4'd2;
    localparam logic [3:0] S_RCP  = 4'd3;
    localparam logic [3:0] S_RSY  = 4'd4;
    localparam logic [3:0] S_RCY  = 4'd5;
    localparam logic [3:0] S_M1   = 4'd6;
    localparam logic [3:0] S_M2   = 4'd7;
    localparam logic [3:0] S_M3   = 4'd8;
    localparam logic [3:0] S_M4   = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0]     r_state;
    logic [3:0]     n_state;
    logic           r_out_valid;
    logic           n_out_valid;
    ocdm_pkg::t_cmd w_cmd;

    // next state and commands
    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                w_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                w_cmd.upd    = 1'b1;
                w_cmd.mul_en = 1'b1;
                w_cmd.mul_op = ocdm_pkg::MUL_UPD;
                n_state      = S_FIN;
            end
            S_FIN: begin
                w_cmd.fin         = 1'b1;
                w_cmd.trig_rd     = 1'b1;
                w_cmd.trig_rd_sel = ocdm_pkg::TRIG_SP;
                n_state           = S_RCP;
            end
            S_RCP: begin
                w_cmd.trig_lat     = 1'b1;
                w_cmd.trig_lat_sel = ocdm_pkg::TRIG_SP;
                w_cmd.trig_rd      = 1'b1;
                w_cmd.trig_rd_sel  = ocdm_pkg::TRIG_CP;
                n_state            = S_RSY;
            end
            S_RSY: begin
                w_cmd.trig_lat     = 1'b1;
                w_cmd.trig_lat_sel = ocdm_pkg::TRIG_CP;
                w_cmd.trig_rd      = 1'b1;
                w_cmd.trig_rd_sel  = ocdm_pkg::TRIG_SY;
                w_cmd.mul_en       = 1'b1;
                w_cmd.mul_op       = ocdm_pkg::MUL_SP_Z;
                n_state            = S_RCY;
            end
            S_RCY: begin
                w_cmd.trig_lat     = 1'b1;
                w_cmd.trig_lat_sel = ocdm_pkg::TRIG_SY;
                w_cmd.trig_rd      = 1'b1;
                w_cmd.trig_rd_sel  = ocdm_pkg::TRIG_CY;
                w_cmd.grab_y       = 1'b1;
                n_state            = S_M1;
            end
            S_M1: begin
                w_cmd.trig_lat     = 1'b1;
                w_cmd.trig_lat_sel = ocdm_pkg::TRIG_CY;
                w_cmd.mul_en       = 1'b1;
                w_cmd.mul_op       = ocdm_pkg::MUL_SY_CP;
                n_state            = S_M2;
            end
            S_M2: begin
                w_cmd.mul_en = 1'b1;
                w_cmd.mul_op = ocdm_pkg::MUL_P_Z;
                n_state      = S_M3;
            end
            S_M3: begin
                w_cmd.grab_z = 1'b1;
                w_cmd.mul_en = 1'b1;
                w_cmd.mul_op = ocdm_pkg::MUL_CY_CP;
                n_state      = S_M4;
            end
            S_M4: begin
                w_cmd.mul_en = 1'b1;
                w_cmd.mul_op = ocdm_pkg::MUL_P_Z;
                n_state      = S_OUT;
            end
            S_OUT: begin
                // wait for the output register to be free
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output word valid flag
    always_comb begin
        if (w_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

### design/orbit_camera_damped_motion.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// orbit_camera_damped_motion: orbit camera with damped yaw, pitch and zoom
// Each input word adds rates or advances one tick, and returns the camera
// position around the target with the current angles and distance.
// ---------------------------------------------------------------------------
//
//  channel  | handshake                  | word
//  ---------+----------------------------+-------------------------------------
//  in       | i_in_valid / o_in_ready    | func, delta_yaw, delta_pitch, delta_zoom
//  out      | o_out_valid / i_out_ready  | pos_x/y/z, yaw_now, pitch_now, zoom_now
//  cfg      | i_cfg_we, i_cfg_idx        | i_cfg_data, written at once
//
//  each word takes the single shared multiplier (six products) and the registered
//  sine table port (four reads) in turn before its result is valid
//  the next word is taken in the cycle after the result is loaded, so no new
//  word is taken while the last one is still in work
//  a result waiting on the output does not block work on the next word; only
//  the final load waits for the output register to be free
//  reset is synchronous, active low, and needs no clearing pass
//
module orbit_camera_damped_motion #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_delta_yaw,
    input  logic signed [31:0] i_delta_pitch,
    input  logic signed [24:0] i_delta_zoom,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic [31:0]        o_yaw_now,
    output logic signed [31:0] o_pitch_now,
    output logic [30:0]        o_zoom_now,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    ocdm_pkg::t_cmd w_cmd;

    // sequencer
    ocdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // arithmetic and state
    ocdm_datapath #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_func),
        .i_delta_yaw   (i_delta_yaw),
        .i_delta_pitch (i_delta_pitch),
        .i_delta_zoom  (i_delta_zoom),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_pos_z       (o_pos_z),
        .o_yaw_now     (o_yaw_now),
        .o_pitch_now   (o_pitch_now),
        .o_zoom_now    (o_zoom_now)
    );

endmodule
